### hw/rtl/uslp_frame_decoder_assert.svh
// assertion macros shared by the frame decoder modules
// expects clk and arst_n in the scope of each use
`ifndef USLP_FRAME_DECODER_ASSERT_SVH
`define USLP_FRAME_DECODER_ASSERT_SVH

// condition must hold in the same cycle
`define USLP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the next cycle
`define USLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/uslp_pkg.sv
// shared types and constants of the transfer frame decoder
// no dependencies
`default_nettype none

package uslp_pkg;

	localparam int MAX_FRAME_BYTES = 1024;
	localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int ADDR_W = 3;
	localparam int CFG_IDX_W = ADDR_W - 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_INITIAL = CFG_IDX_W'(0);

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// summary status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CRC = 2'd1;
	localparam logic [1:0] ST_LENGTH = 2'd2;
	localparam logic [1:0] ST_EARLY = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [3:0]  version;
		logic [15:0] spacecraft_id;
		logic        source_or_dest;
		logic [5:0]  virtual_channel;
		logic [3:0]  map_id;
		logic        truncated;
		logic [2:0]  frame_flags;
		logic [2:0]  construction_rule;
		logic [4:0]  upper_proto;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  version;
		logic [15:0] spacecraft_id;
		logic        source_or_dest;
		logic [5:0]  virtual_channel;
		logic [3:0]  map_id;
		logic        truncated;
		logic [2:0]  frame_flags;
		logic [2:0]  construction_rule;
		logic [4:0]  upper_proto;
	} hdr_t;

	// command from the front end to the output side
	typedef struct packed {
		logic       emit;
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic       done;
		logic [1:0] status;
		hdr_t       hdr;
	} cmd_t;

endpackage

`default_nettype wire

### hw/rtl/uslp_front.sv
// front end: header parse, crc, framing decisions per accepted byte
// depends on uslp_pkg and uslp_frame_decoder_assert.svh
`default_nettype none
`include "uslp_frame_decoder_assert.svh"

module uslp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire uslp_pkg::in_item_t item,
	input  wire logic [15:0]     crc_init,
	input  wire logic            queue_full,
	output logic                 push,
	output uslp_pkg::cmd_t       push_cmd
);

	localparam logic [15:0] FULL_MIN_BYTES = 16'd10;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic [7:0]  x;
		c = crc;
		x = b;
		for (int i = 0; i < 8; i++) begin
			if (c[15] ^ x[7]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
			x = {x[6:0], 1'b0};
		end
		return c;
	endfunction

	logic [15:0] pos_q, decl_q, crc_q;
	logic [7:0]  dly0_q, dly1_q;
	uslp_pkg::hdr_t hdr_q;
	logic [2:0]  izl_q;
	logic        lerr_q;

	uslp_pkg::hdr_t hdr_b, hdr_n;
	logic [15:0] decl_b, decl_n, crc_b, crc_n, trailer;
	logic [2:0]  izl_b, izl_n;
	logic        lerr_b, lerr_n;
	logic [7:0]  d;
	logic        first, accept, emit, done, crc_bad, full_end;
	logic [1:0]  kind, status;

	assign d = item.data_byte;
	assign first = (pos_q == 16'd0);
	assign item_ready = !queue_full;
	assign accept = item_valid && item_ready;

	always_comb begin
		// frame start clears the per-frame state and reseeds the crc
		hdr_b = first ? '0 : hdr_q;
		decl_b = first ? 16'd0 : decl_q;
		izl_b = first ? 3'd0 : izl_q;
		lerr_b = first ? 1'b0 : lerr_q;
		crc_b = first ? crc_init : crc_q;
		hdr_n = hdr_b;
		decl_n = decl_b;
		izl_n = izl_b;
		lerr_n = lerr_b;
		case (pos_q)
			16'd0: begin
				hdr_n.version = d[7:4];
				hdr_n.spacecraft_id = {d[3:0], 12'd0};
			end
			16'd1: begin
				hdr_n.spacecraft_id[11:4] = d;
			end
			16'd2: begin
				hdr_n.spacecraft_id[3:0] = d[7:4];
				hdr_n.source_or_dest = d[3];
				hdr_n.virtual_channel = {d[2:0], 3'd0};
			end
			16'd3: begin
				hdr_n.virtual_channel[2:0] = d[7:5];
				hdr_n.map_id = d[4:1];
				hdr_n.truncated = d[0];
			end
			16'd4: begin
				if (hdr_b.truncated) begin
					hdr_n.construction_rule = d[7:5];
					hdr_n.upper_proto = d[4:0];
				end else begin
					decl_n = {d, 8'd0};
				end
			end
			16'd5: begin
				if (!hdr_b.truncated) begin
					decl_n[7:0] = d;
				end
			end
			16'd6: begin
				if (!hdr_b.truncated) begin
					hdr_n.frame_flags = {d[7], d[6], d[3]};
					izl_n = d[2:0];
					if (decl_b < FULL_MIN_BYTES + {13'd0, d[2:0]} || decl_b > uslp_pkg::MAX_LEN) begin
						lerr_n = 1'b1;
					end
				end
			end
			default: begin
				// data-field header byte follows the insert zone
				if (!hdr_b.truncated && pos_q == 16'd7 + {13'd0, izl_b}) begin
					hdr_n.construction_rule = d[7:5];
					hdr_n.upper_proto = d[4:0];
				end
			end
		endcase
		if (hdr_n.truncated && pos_q >= uslp_pkg::MAX_LEN) begin
			lerr_n = 1'b1;
		end

		// the byte two behind leaves the delay line
		crc_n = (pos_q >= 16'd2) ? crc_feed(crc_b, dly0_q) : crc_b;
		emit = 1'b0;
		kind = uslp_pkg::KIND_PAYLOAD;
		if (pos_q >= 16'd2 && !lerr_n) begin
			if (hdr_n.truncated) begin
				emit = (pos_q >= 16'd7);
			end else if (pos_q >= 16'd9) begin
				if (pos_q < 16'd9 + {13'd0, izl_n}) begin
					emit = 1'b1;
					kind = uslp_pkg::KIND_INSERT;
				end else if (pos_q >= 16'd10 + {13'd0, izl_n}) begin
					emit = 1'b1;
				end
			end
		end

		trailer = {dly1_q, d};
		crc_bad = (crc_n != trailer);
		full_end = !hdr_n.truncated && pos_q >= 16'd6 && !lerr_n &&
			({1'b0, pos_q} + 17'd1 == {1'b0, decl_n});
		done = 1'b0;
		status = uslp_pkg::ST_OK;
		if (full_end) begin
			done = 1'b1;
			status = crc_bad ? uslp_pkg::ST_CRC : uslp_pkg::ST_OK;
		end else if (item.last_byte) begin
			done = 1'b1;
			if (lerr_n) begin
				status = uslp_pkg::ST_LENGTH;
			end else if (hdr_n.truncated && pos_q >= 16'd6) begin
				status = crc_bad ? uslp_pkg::ST_CRC : uslp_pkg::ST_OK;
			end else if (hdr_n.truncated) begin
				status = uslp_pkg::ST_LENGTH;
			end else begin
				status = uslp_pkg::ST_EARLY;
			end
		end
	end

	assign push = accept && (emit || done);
	assign push_cmd = '{emit: emit, kind: kind, byte_value: dly0_q, done: done,
		status: status, hdr: hdr_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			decl_q <= '0;
			crc_q <= '0;
			dly0_q <= '0;
			dly1_q <= '0;
			hdr_q <= '0;
			izl_q <= '0;
			lerr_q <= 1'b0;
		end else if (accept) begin
			decl_q <= decl_n;
			crc_q <= crc_n;
			hdr_q <= hdr_n;
			izl_q <= izl_n;
			lerr_q <= lerr_n;
			if (done) begin
				pos_q <= '0;
			end else begin
				dly0_q <= dly1_q;
				dly1_q <= d;
				pos_q <= (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
			end
		end
	end

	`USLP_ASSERT_NEXT(a_pos_advances, accept && !done, pos_q != 16'd0,
		"position went back to zero without a frame end")

endmodule

`default_nettype wire

### hw/rtl/uslp_queue.sv
// short queue of commands between front end and output side
// depends on uslp_pkg and uslp_frame_decoder_assert.svh
`default_nettype none
`include "uslp_frame_decoder_assert.svh"

module uslp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire uslp_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output uslp_pkg::cmd_t      head
);

	localparam logic [uslp_pkg::QPTR_W-1:0] LAST_PTR =
		uslp_pkg::QPTR_W'(uslp_pkg::QUEUE_DEPTH - 1);
	localparam logic [uslp_pkg::QPTR_W-1:0] PTR_ONE = uslp_pkg::QPTR_W'(1);
	localparam logic [uslp_pkg::QCNT_W-1:0] DEPTH_CNT =
		uslp_pkg::QCNT_W'(uslp_pkg::QUEUE_DEPTH);
	localparam logic [uslp_pkg::QCNT_W-1:0] CNT_ONE = uslp_pkg::QCNT_W'(1);

	uslp_pkg::cmd_t entry_q [uslp_pkg::QUEUE_DEPTH];
	logic [uslp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [uslp_pkg::QCNT_W-1:0] count_q;
	logic do_pop;

	assign full = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + CNT_ONE;
				2'b01: count_q <= count_q - CNT_ONE;
				default: count_q <= count_q;
			endcase
		end
	end

	`USLP_ASSERT_NOW(a_no_overflow, push, !full, "push into a full queue")
	`USLP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_CNT, "queue count out of range")

endmodule

`default_nettype wire

### hw/rtl/uslp_back.sv
// output side: turns commands into byte and summary transfers
// depends on uslp_pkg and uslp_frame_decoder_assert.svh
`default_nettype none
`include "uslp_frame_decoder_assert.svh"

module uslp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire uslp_pkg::cmd_t head,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_ready,
	output uslp_pkg::out_item_t result
);

	logic phase_q;
	logic valid_q;
	uslp_pkg::out_item_t result_q;
	logic load, send_byte;
	uslp_pkg::out_item_t next_item;

	assign load = !valid_q || result_ready;
	// byte first, summary on a later cycle when the command carries both
	assign send_byte = head.emit && !phase_q;
	assign pop = load && head_valid && !(send_byte && head.done);

	always_comb begin
		next_item = '0;
		if (send_byte) begin
			next_item.kind = head.kind;
			next_item.byte_value = head.byte_value;
		end else begin
			next_item.kind = uslp_pkg::KIND_SUMMARY;
			next_item.version = head.hdr.version;
			next_item.spacecraft_id = head.hdr.spacecraft_id;
			next_item.source_or_dest = head.hdr.source_or_dest;
			next_item.virtual_channel = head.hdr.virtual_channel;
			next_item.map_id = head.hdr.map_id;
			next_item.truncated = head.hdr.truncated;
			next_item.frame_flags = head.hdr.frame_flags;
			next_item.construction_rule = head.hdr.construction_rule;
			next_item.upper_proto = head.hdr.upper_proto;
			next_item.status = head.status;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			result_q <= next_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				phase_q <= send_byte && head.done;
			end
		end
	end

	assign result_valid = valid_q;
	assign result = result_q;

	`USLP_ASSERT_NOW(a_phase_ctx, phase_q, head_valid && head.emit && head.done,
		"summary phase without a byte-and-summary command at the head")

endmodule

`default_nettype wire

### hw/rtl/uslp_frame_decoder.sv
// top level of the transfer frame decoder: config register, front end, queue, output side
// depends on uslp_pkg, uslp_front, uslp_queue, uslp_back
// path: a command enters the queue at the accepting edge of its byte, then the output register once that is free
// throughput: one byte per cycle; a frame end with a pending byte sends the byte, then the summary,
// input stalls only while the four-entry queue is full
// reset: position, delay line, crc, header state and crc seed clear, queue empty, no result
`default_nettype none

module uslp_frame_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// byte stream in
	input  wire logic                       item_valid,
	output logic                            item_ready,
	input  wire uslp_pkg::in_item_t         item,
	// results out
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output uslp_pkg::out_item_t             result,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [uslp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic [15:0] crc_init_q;
	logic [uslp_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic cfg_write;

	logic queue_full, push, pop, head_valid;
	uslp_pkg::cmd_t push_cmd, head;

	// register index from the word address; no wait states
	assign cfg_idx = paddr[uslp_pkg::ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_init_q <= '0;
		end else if (cfg_write && cfg_idx == uslp_pkg::CFG_CRC_INITIAL) begin
			crc_init_q <= pwdata[15:0];
		end
	end

	// read back: only the crc seed is mapped, the rest reads zero
	always_comb begin
		prdata = '0;
		if (cfg_idx == uslp_pkg::CFG_CRC_INITIAL) begin
			prdata = {16'd0, crc_init_q};
		end
	end

	// front end: takes a byte whenever the queue has room
	uslp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.crc_init   (crc_init_q),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// decouples byte intake from result stalls
	uslp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// output register, one transfer per cycle unless result_ready holds it
	uslp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
